@@ hw/rtl/csa_pkg.sv @@
// ----------------------------------------------------------------------------
// csa_pkg: shared types and constants
// Count and index widths and the per-cell control bundle.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int CNT_BITS   = 6;
  localparam int INDEX_BITS = 6;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  // control broadcast from the sequencer to one cell
  typedef struct packed {
    logic load;   // capture the incoming key, clear count
    logic shift;  // take neighbor contents (drain)
    logic cmp;    // a new element is on the key bus
  } cell_ctrl_t;

endpackage

@@ hw/rtl/csa_cell.sv @@
// ----------------------------------------------------------------------------
// csa_cell: one storage cell of the chain
// Holds one key and its running count; counts later smaller keys and hands
// its contents to the lower neighbor while the chain drains.
// ----------------------------------------------------------------------------
module csa_cell #(
  parameter int VALUE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  csa_pkg::cell_ctrl_t            ctrl,
  input  logic [VALUE_BITS-1:0]          in_key,
  input  logic                           nb_valid,
  input  logic [VALUE_BITS-1:0]          nb_key,
  input  logic [csa_pkg::CNT_BITS-1:0]   nb_count,
  output logic                           valid,
  output logic [VALUE_BITS-1:0]          key,
  output logic [csa_pkg::CNT_BITS-1:0]   count
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key   <= nb_key;
      count <= nb_count;
    end else if (ctrl.load) begin
      key   <= in_key;
      count <= '0;
    end else if (ctrl.cmp && valid && (in_key < key) && (count != csa_pkg::CNT_MAX)) begin
      count <= count + csa_pkg::CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= nb_valid;
    end else if (ctrl.load) begin
      valid <= 1'b1;
    end
  end

endmodule

@@ hw/rtl/count_smaller_after_self.sv @@
// ----------------------------------------------------------------------------
// count_smaller_after_self: count of later smaller elements, per element
// Stores a run of signed values in a chain of cells and reports, for each
// element in arrival order, how many later elements are strictly smaller.
// ----------------------------------------------------------------------------
// Usage:
//   Input: an element transfers on a rising edge with start high and busy
//   low. value is two's complement (VALUE_BITS wide); last closes the run.
//   While loading, busy stays low, so one element can transfer every cycle.
//   Each element is compared against all stored cells in the cycle it
//   arrives; the chain holds up to MAX_ELEMS elements. Elements arriving on
//   a full chain are dropped and set the overflow flag for the run.
//   Output: the cycle after the closing element transfers, the chain
//   drains one cell per cycle toward cell 0. strobe is high for exactly one
//   cycle per result, with index, count, last_result and overflow valid in
//   that cycle. A run of N stored elements gives N results in back to
//   back cycles; busy is high while they are presented. The drain rate
//   is set by the single output shift of the chain.
//   The receiver cannot stall; results are simply presented once.
//   Reset (rst, synchronous) empties the chain and clears the flag; the
//   same happens automatically after the final result of a run.
// ----------------------------------------------------------------------------
module count_smaller_after_self #(
  parameter int MAX_ELEMS  = 64,
  parameter int VALUE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [VALUE_BITS-1:0]     value,
  input  logic                             last,
  output logic                             strobe,
  output logic [csa_pkg::INDEX_BITS-1:0]   index,
  output logic [csa_pkg::CNT_BITS-1:0]     count,
  output logic                             last_result,
  output logic                             overflow
);

  localparam int FW = $clog2(MAX_ELEMS + 1);
  localparam int IW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;

  typedef enum logic {
    IDLE,
    DRAIN
  } state_t;

  state_t          state;
  logic [FW-1:0]   fill;     // number of stored elements
  logic [IW-1:0]   idx;      // index of the result at cell 0
  logic            dropped;

  logic            accept;
  logic            full;
  logic            final_res;
  logic [VALUE_BITS-1:0] key_in;

  // chain taps; entry MAX_ELEMS is the empty end of the chain
  logic                          c_valid [MAX_ELEMS+1];
  logic [VALUE_BITS-1:0]         c_key   [MAX_ELEMS+1];
  logic [csa_pkg::CNT_BITS-1:0]  c_count [MAX_ELEMS+1];

  assign accept = start && !busy;
  assign full   = (fill == FW'(MAX_ELEMS));
  // flip the sign bit: signed order becomes unsigned order
  assign key_in = VALUE_BITS'(value) ^ {1'b1, {(VALUE_BITS-1){1'b0}}};
  assign final_res = (FW'(idx) == fill - FW'(1));

  assign c_valid[MAX_ELEMS] = 1'b0;
  assign c_key[MAX_ELEMS]   = '0;
  assign c_count[MAX_ELEMS] = '0;

  genvar k;
  generate
    for (k = 0; k < MAX_ELEMS; k++) begin : g_cell
      csa_pkg::cell_ctrl_t ctrl;
      assign ctrl.load  = accept && !full && (fill == FW'(k));
      assign ctrl.shift = (state == DRAIN);
      // a dropped element never touches the counts
      assign ctrl.cmp   = accept && !full;

      csa_cell #(
        .VALUE_BITS (VALUE_BITS)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .in_key   (key_in),
        .nb_valid (c_valid[k+1]),
        .nb_key   (c_key[k+1]),
        .nb_count (c_count[k+1]),
        .valid    (c_valid[k]),
        .key      (c_key[k]),
        .count    (c_count[k])
      );
    end
  endgenerate

  // sequencer: load phase, then drain one result per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      fill    <= '0;
      idx     <= '0;
      dropped <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            if (full) begin
              dropped <= 1'b1;
            end else begin
              fill <= fill + FW'(1);
            end
            if (last) begin
              state <= DRAIN;
              idx   <= '0;
            end
          end
        end
        DRAIN: begin
          if (final_res) begin
            state   <= IDLE;
            fill    <= '0;
            idx     <= '0;
            dropped <= 1'b0;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign busy        = (state == DRAIN);
  assign strobe      = (state == DRAIN);
  assign index       = csa_pkg::INDEX_BITS'(idx);
  assign count       = c_count[0];
  assign last_result = strobe && final_res;
  assign overflow    = dropped;

endmodule

@@ hw/rtl/csa_checker.sv @@
// ----------------------------------------------------------------------------
// csa_checker: port-level checks for count_smaller_after_self
// Checks the shape of a result burst as seen on the top-level ports.
// ----------------------------------------------------------------------------
module csa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           busy,
  input logic                           strobe,
  input logic [csa_pkg::INDEX_BITS-1:0] index,
  input logic                           last_result
);

  // burst starts at index 0
  a_first_index: assert property (@(posedge clk) disable iff (rst)
    $rose(strobe) |-> (index == '0))
    else $error("result burst does not start at index 0");

  // results are contiguous until the final one
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_result) |=> strobe)
    else $error("gap in result burst");

  // indexes step by one
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_result) |=> (index == $past(index) + csa_pkg::INDEX_BITS'(1)))
    else $error("result index did not advance by one");

  // block is free again after the final result
  a_release: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_result) |=> (!busy && !strobe))
    else $error("block still busy after final result");

endmodule

bind count_smaller_after_self csa_checker u_csa_checker (
  .clk         (clk),
  .rst         (rst),
  .busy        (busy),
  .strobe      (strobe),
  .index       (index),
  .last_result (last_result)
);

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for count_smaller_after_self
// Feeds runs of signed values with random gaps on the start side. A
// per-element predictor keeps its own copy of stored keys, counts, fill
// level and drop flag, and queues the results each closing element
// should produce. Every strobed result is checked field by field against
// the oldest queued result.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_ELEMS  = 64;
  localparam int VALUE_BITS = 16;
  localparam int IDLE_LIMIT = 2000;  // far above the longest gap and the longest drain
  localparam int TAIL_WAIT  = MAX_ELEMS + 16;

  // one input element
  typedef struct {
    logic signed [VALUE_BITS-1:0] value;
    logic                         closing;
  } element_t;

  // one expected result
  typedef struct {
    logic [csa_pkg::INDEX_BITS-1:0] index;
    logic [csa_pkg::CNT_BITS-1:0]   count;
    logic                           last_result;
    logic                           overflow;
  } result_t;

  // value styles for generated runs
  typedef enum int {
    VAL_ANY,       // full 16-bit range
    VAL_NARROW,    // a few values near zero, lots of ties
    VAL_EXTREME,   // min, max, zero, -1
    VAL_MIXED      // per element pick of the above
  } value_style_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  logic signed [VALUE_BITS-1:0]   value = '0;
  logic                           last = 1'b0;
  logic                           strobe;
  logic [csa_pkg::INDEX_BITS-1:0] index;
  logic [csa_pkg::CNT_BITS-1:0]   count;
  logic                           last_result;
  logic                           overflow;

  count_smaller_after_self #(
    .MAX_ELEMS (MAX_ELEMS),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .last       (last),
    .strobe     (strobe),
    .index      (index),
    .count      (count),
    .last_result(last_result),
    .overflow   (overflow)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of what the chain should hold.
  // --------------------------------------------------------------------------
  logic signed [VALUE_BITS-1:0] held_values [MAX_ELEMS];
  logic [csa_pkg::CNT_BITS-1:0] held_counts [MAX_ELEMS];
  int                           held_fill = 0;
  logic                         held_dropped = 1'b0;

  element_t pending_elements[$];   // not yet offered to the block
  result_t  expected_results[$];   // predicted, not yet strobed

  int  error_count     = 0;
  int  results_checked = 0;
  int  runs_closed     = 0;
  int  overflow_runs   = 0;
  int  idle_cycles     = 0;
  bit  took            = 1'b0;     // input transfer at the last rising edge
  int  gap_left        = 0;
  int  burst_left      = 0;
  element_t next_elem;

  // Fold one accepted element into the predicted state. A closing element
  // queues one result per stored element and clears the state, same as
  // the block does after its final result.
  task automatic absorb_element(input element_t e);
    result_t r;
    if (held_fill < MAX_ELEMS) begin
      for (int i = 0; i < held_fill; i++) begin
        if (e.value < held_values[i] && held_counts[i] != csa_pkg::CNT_MAX)
          held_counts[i] = held_counts[i] + 1'b1;
      end
      held_values[held_fill] = e.value;
      held_counts[held_fill] = '0;
      held_fill++;
    end else begin
      // beyond capacity: dropped, counts untouched
      held_dropped = 1'b1;
    end
    if (e.closing) begin
      for (int i = 0; i < held_fill; i++) begin
        r.index       = csa_pkg::INDEX_BITS'(i);
        r.count       = held_counts[i];
        r.last_result = (i + 1 == held_fill);
        r.overflow    = held_dropped;
        expected_results.push_back(r);
      end
      runs_closed++;
      if (held_dropped) overflow_runs++;
      held_fill    = 0;
      held_dropped = 1'b0;
      for (int i = 0; i < MAX_ELEMS; i++) held_counts[i] = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_element(input logic signed [VALUE_BITS-1:0] v, input logic c);
    element_t e;
    e.value   = v;
    e.closing = c;
    pending_elements.push_back(e);
  endtask

  function automatic logic signed [VALUE_BITS-1:0] pick_value(input value_style_t style);
    value_style_t s;
    s = style;
    if (s == VAL_MIXED) s = value_style_t'($urandom_range(0, 2));
    case (s)
      VAL_NARROW: pick_value = VALUE_BITS'($signed($urandom_range(0, 6)) - 3);
      VAL_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       pick_value = {1'b1, {(VALUE_BITS-1){1'b0}}};
          1:       pick_value = {1'b0, {(VALUE_BITS-1){1'b1}}};
          2:       pick_value = '0;
          default: pick_value = '1;
        endcase
      end
      default: pick_value = VALUE_BITS'($urandom);
    endcase
  endfunction

  // A run of len elements, the final one marked closing.
  task automatic add_run(input int len, input value_style_t style);
    for (int i = 0; i < len; i++) add_element(pick_value(style), i == len - 1);
  endtask

  // Mostly short gaps, a few long ones, and now and then a burst of
  // back to back transfers.
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: inputs change on the falling edge. A new element is put up
  // once the previous one has transferred and its gap has run out.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left  = 0;
    end else if (!start || took) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_elements.size() != 0) begin
        next_elem = pending_elements.pop_front();
        value    <= next_elem.value;
        last     <= next_elem.closing;
        start    <= 1'b1;
        gap_left  = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: sample on the rising edge. Input transfers feed the
  // predictor; strobed results are checked against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      took = 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        next_elem.value   = value;
        next_elem.closing = last;
        absorb_element(next_elem);
      end
      if (strobe) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: index %0d count %0d", index, count);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (index !== want.index) begin
            $error("index: expected %0d, got %0d", want.index, index);
            error_count++;
          end
          if (count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count);
            error_count++;
          end
          if (last_result !== want.last_result) begin
            $error("last_result: expected %0b, got %0b", want.last_result, last_result);
            error_count++;
          end
          if (overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, overflow);
            error_count++;
          end
        end
      end
    end
    if (took || strobe) idle_cycles = 0;
    else idle_cycles++;
  end

  // Watchdog: too long with no transfer on either side ends the run.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("count_smaller_after_self: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int placed;

    // directed: single element runs at max and at min, then extremes with ties
    add_element(16'sh7FFF, 1'b1);
    add_element(16'sh8000, 1'b1);
    add_element(16'sh7FFF, 1'b0);
    add_element(16'sh8000, 1'b0);
    add_element(16'sh0000, 1'b0);
    add_element(16'sh0000, 1'b0);
    add_element(16'shFFFF, 1'b0);
    add_element(16'sh7FFF, 1'b0);
    add_element(16'sh8000, 1'b0);
    add_element(16'sh0001, 1'b1);
    // strictly rising, then strictly falling, then all equal
    for (int i = 0; i < 4; i++) add_element(VALUE_BITS'(i * 1000 - 1500), i == 3);
    for (int i = 0; i < 4; i++) add_element(VALUE_BITS'(1500 - i * 1000), i == 3);
    for (int i = 0; i < 4; i++) add_element(16'sh5555, i == 3);

    // random: mostly short runs, with two long ones wedged in
    placed = 0;
    while (placed < 40) begin
      int len;
      len = $urandom_range(1, 10);
      add_run(len, value_style_t'($urandom_range(0, 3)));
      placed += len;
    end
    // exactly full, descending so the first count tops out at 63
    begin
      logic signed [VALUE_BITS-1:0] v;
      v = 16'sh7FFF;
      for (int i = 0; i < MAX_ELEMS; i++) begin
        add_element(v, i == MAX_ELEMS - 1);
        v = v - VALUE_BITS'($urandom_range(1, 500));
      end
    end
    placed = 0;
    while (placed < 30) begin
      int len;
      len = $urandom_range(1, 8);
      add_run(len, value_style_t'($urandom_range(0, 3)));
      placed += len;
    end
    // past capacity: drops before and on the closing element
    add_run(MAX_ELEMS + 3, VAL_MIXED);
    placed = 0;
    while (placed < 30) begin
      int len;
      len = $urandom_range(1, 8);
      add_run(len, value_style_t'($urandom_range(0, 3)));
      placed += len;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_elements.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end

    $display("covered %0d closed runs (%0d with overflow), %0d results checked",
             runs_closed, overflow_runs, results_checked);
    if (error_count == 0) begin
      $display("count_smaller_after_self: match");
    end else begin
      $display("count_smaller_after_self: mismatch");
    end
    $finish;
  end

endmodule
